// ----- sv/svd_pkg.sv -----
// ----------------------------------------------------------------------------
// svd_pkg
// Types and constants shared by the left singular vector recovery block:
// item and result payloads, register indexes and the divider cell word.
// ----------------------------------------------------------------------------
package svd_pkg;

	// item kinds
	localparam logic [1:0] KIND_LOAD_A     = 2'd0;
	localparam logic [1:0] KIND_LOAD_V     = 2'd1;
	localparam logic [1:0] KIND_LOAD_SIGMA = 2'd2;
	localparam logic [1:0] KIND_COMPUTE    = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_ROWS_IN_USE = 2'd0;
	localparam logic [1:0] REG_COLS_IN_USE = 2'd1;
	localparam logic [1:0] REG_SIGMA_FLOOR = 2'd2;

	// magnitude of sum * 256: 35-bit magnitude shifted by 8
	localparam int DIV_W = 43;
	localparam int SUM_W = 35;
	localparam int DVS_W = 15;

	typedef struct packed {
		logic [1:0]         kind;
		logic [2:0]         row;
		logic [2:0]         col;
		logic signed [15:0] value;
	} item_t;

	typedef struct packed {
		logic [2:0]         out_row;
		logic [2:0]         out_col;
		logic signed [31:0] result_value;
		logic               last;
	} result_t;

	typedef struct packed {
		logic [2:0] row;
		logic [2:0] col;
		logic       last;
		logic       neg;
	} div_tag_t;

	typedef struct packed {
		logic             valid;
		logic [DVS_W-1:0] rem;
		logic [DIV_W-1:0] nq;
		logic [DVS_W-1:0] dvs;
		div_tag_t         tag;
	} div_cell_t;

endpackage

// ----- sv/svd_ram.sv -----
// ----------------------------------------------------------------------------
// svd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module svd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/svd_div_cell.sv -----
// ----------------------------------------------------------------------------
// svd_div_cell
// One restoring division cell: produces one quotient bit and hands the
// partial remainder and shifted word to the next cell of the chain.
// ----------------------------------------------------------------------------
module svd_div_cell
	import svd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  div_cell_t cell_in,
	output div_cell_t cell_out
);

	logic [DVS_W:0] trial;
	logic [DVS_W:0] diff;
	logic           ge;
	div_cell_t      next_cell;

	// trial subtract of the divisor from the shifted remainder
	always_comb begin
		trial = {cell_in.rem, cell_in.nq[DIV_W-1]};
		diff  = trial - {1'b0, cell_in.dvs};
		ge    = trial >= {1'b0, cell_in.dvs};
		next_cell       = cell_in;
		next_cell.rem   = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		next_cell.nq    = {cell_in.nq[DIV_W-2:0], ge};
	end

	// hand off to the neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_out <= '0;
		end else if (en) begin
			cell_out <= next_cell;
		end
	end

endmodule

// ----- sv/svd_left_vector_recovery.sv -----
// ----------------------------------------------------------------------------
// svd_left_vector_recovery
// U = (A * V) / S column by column, with a chain of divider cells.
// ----------------------------------------------------------------------------
// A load item (A element, V element or singular value) is accepted back to
// back while no compute is running. A compute item emits rows_in_use *
// cols_in_use results; one multiply-accumulate per cycle is shared by all
// dot products while no result stall holds the chain, so a compute issues
// rows * cols * cols products, and each dot product passes three register
// stages of read, multiply and accumulate, 43 division cells and one output
// register before its result appears.
// Items are stalled from the compute transfer until the last result has been
// taken. A result stall freezes the whole chain. Configuration writes are
// always taken.
module svd_left_vector_recovery
	import svd_pkg::*;
#(
	parameter int MAX_ROWS = 8,
	parameter int MAX_COLS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int A_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int V_DEPTH = MAX_COLS * MAX_COLS;
	localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
	localparam int V_AW    = (V_DEPTH > 1) ? $clog2(V_DEPTH) : 1;
	localparam int KW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	typedef struct packed {
		logic             first;
		logic             end_dot;
		logic             zero;
		logic [DVS_W-1:0] dvs;
		logic [2:0]       row;
		logic [2:0]       col;
		logic             last;
	} mac_tag_t;

	state_t state_q;
	logic [3:0]  rows_cfg_q, cols_cfg_q;
	logic [15:0] floor_cfg_q;
	logic [3:0]  nr_q, nc_q;
	logic [15:0] floor_q;
	logic [2:0]  k_q, m_q, n_q;
	logic [15:0] sigma_q [MAX_COLS];

	logic adv, accept, compute_go, issue, last_issue;
	logic n_end, m_end, k_end;
	logic [15:0] sigma_k;
	mac_tag_t tag_s0;
	logic [15:0] a_rd, v_rd;

	logic     valid_s1, valid_s2, valid_s3;
	mac_tag_t tag_s1, tag_s2, tag_s3;
	logic signed [31:0]    prod_s2;
	logic signed [SUM_W-1:0] acc_q, acc_next, sum_s3;
	logic [SUM_W-1:0] mag;

	div_cell_t chain [DIV_W+1];
	logic [DIV_W-1:0] quo;
	logic [31:0] sat_value;

	logic    result_valid_q;
	result_t result_q;

	// handshake
	assign adv        = !(result_valid_q && result_stall);
	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign compute_go = accept && (item.kind == KIND_COMPUTE);
	assign cfg_ready  = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q  <= 4'd8;
			cols_cfg_q  <= 4'd8;
			floor_cfg_q <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROWS_IN_USE: rows_cfg_q  <= cfg_data[3:0];
				REG_COLS_IN_USE: cols_cfg_q  <= cfg_data[3:0];
				REG_SIGMA_FLOOR: floor_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// singular value registers
	always_ff @(posedge clk) begin
		if (accept && item.kind == KIND_LOAD_SIGMA && 32'(item.col) < MAX_COLS) begin
			sigma_q[item.col[KW-1:0]] <= item.value;
		end
	end

	// loop counters
	assign n_end      = ({1'b0, n_q} + 4'd1) == nc_q;
	assign m_end      = ({1'b0, m_q} + 4'd1) == nr_q;
	assign k_end      = ({1'b0, k_q} + 4'd1) == nc_q;
	assign issue      = (state_q == ST_RUN) && adv;
	assign last_issue = n_end && m_end && k_end;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			m_q     <= '0;
			n_q     <= '0;
			nr_q    <= 4'd1;
			nc_q    <= 4'd1;
			floor_q <= 16'd1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (compute_go) begin
						state_q <= ST_RUN;
						k_q     <= '0;
						m_q     <= '0;
						n_q     <= '0;
						nr_q    <= (rows_cfg_q == 4'd0) ? 4'd1 :
							(32'(rows_cfg_q) > MAX_ROWS) ? 4'(MAX_ROWS) : rows_cfg_q;
						nc_q    <= (cols_cfg_q == 4'd0) ? 4'd1 :
							(32'(cols_cfg_q) > MAX_COLS) ? 4'(MAX_COLS) : cols_cfg_q;
						floor_q <= (floor_cfg_q == 16'd0) ? 16'd1 : floor_cfg_q;
					end
				end
				ST_RUN: begin
					if (issue) begin
						if (last_issue) begin
							state_q <= ST_DRAIN;
						end
						if (n_end) begin
							n_q <= '0;
							if (m_end) begin
								m_q <= '0;
								k_q <= k_q + 3'd1;
							end else begin
								m_q <= m_q + 3'd1;
							end
						end else begin
							n_q <= n_q + 3'd1;
						end
					end
				end
				ST_DRAIN: begin
					if (result_valid_q && !result_stall && result_q.last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// column tag for the issued product
	always_comb begin
		sigma_k        = sigma_q[k_q[KW-1:0]];
		tag_s0.first   = (n_q == 3'd0);
		tag_s0.end_dot = n_end;
		tag_s0.zero    = sigma_k[15] || ({1'b0, sigma_k[14:0]} < floor_q);
		tag_s0.dvs     = tag_s0.zero ? 15'd1 : sigma_k[14:0];
		tag_s0.row     = m_q;
		tag_s0.col     = k_q;
		tag_s0.last    = last_issue;
	end

	// element stores
	svd_ram #(.WIDTH(16), .DEPTH(A_DEPTH)) u_a_ram (
		.clk   (clk),
		.we    (accept && item.kind == KIND_LOAD_A && 32'(item.row) < MAX_ROWS
			&& 32'(item.col) < MAX_COLS),
		.waddr (A_AW'(32'(item.row) * MAX_COLS + 32'(item.col))),
		.wdata (item.value),
		.re    (adv),
		.raddr (A_AW'(32'(m_q) * MAX_COLS + 32'(n_q))),
		.rdata (a_rd)
	);

	svd_ram #(.WIDTH(16), .DEPTH(V_DEPTH)) u_v_ram (
		.clk   (clk),
		.we    (accept && item.kind == KIND_LOAD_V && 32'(item.row) < MAX_COLS
			&& 32'(item.col) < MAX_COLS),
		.waddr (V_AW'(32'(item.row) * MAX_COLS + 32'(item.col))),
		.wdata (item.value),
		.re    (adv),
		.raddr (V_AW'(32'(n_q) * MAX_COLS + 32'(k_q))),
		.rdata (v_rd)
	);

	// multiply-accumulate pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2 && tag_s2.end_dot;
		end
	end

	assign acc_next = (tag_s2.first ? SUM_W'(0) : acc_q) + SUM_W'(prod_s2);

	// multiply-accumulate pipeline data
	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1  <= tag_s0;
			tag_s2  <= tag_s1;
			prod_s2 <= $signed(a_rd) * $signed(v_rd);
			if (valid_s2) begin
				acc_q  <= acc_next;
				sum_s3 <= tag_s2.zero ? '0 : acc_next;
				tag_s3 <= tag_s2;
			end
		end
	end

	// division chain input: magnitude of sum * 256
	assign mag = sum_s3[SUM_W-1] ? SUM_W'(-sum_s3) : SUM_W'(sum_s3);

	always_comb begin
		chain[0].valid    = valid_s3;
		chain[0].rem      = '0;
		chain[0].nq       = {mag, 8'd0};
		chain[0].dvs      = tag_s3.dvs;
		chain[0].tag.row  = tag_s3.row;
		chain[0].tag.col  = tag_s3.col;
		chain[0].tag.last = tag_s3.last;
		chain[0].tag.neg  = sum_s3[SUM_W-1];
	end

	// chain of division cells, one quotient bit each
	for (genvar i = 0; i < DIV_W; i++) begin : g_cell
		svd_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.cell_in  (chain[i]),
			.cell_out (chain[i+1])
		);
	end

	// sign and saturation
	always_comb begin
		quo = chain[DIV_W].nq;
		if (chain[DIV_W].tag.neg) begin
			sat_value = (quo > DIV_W'(33'h080000000)) ? 32'h80000000 : (32'd0 - quo[31:0]);
		end else begin
			sat_value = (quo > DIV_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : quo[31:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= chain[DIV_W].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q.out_row      <= chain[DIV_W].tag.row;
			result_q.out_col      <= chain[DIV_W].tag.col;
			result_q.result_value <= sat_value;
			result_q.last         <= chain[DIV_W].tag.last;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// results only come out of a running compute
	a_result_in_compute: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (state_q != ST_IDLE))
		else $error("result outside a compute");

	// the final result of a compute empties the chain
	a_drained_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && !result_stall && result_q.last) |=> !result_valid_q)
		else $error("result after the final element");

	// a compute transfer starts issue in the next cycle
	a_compute_starts: assert property (@(posedge clk) disable iff (!arst_n)
		compute_go |=> (state_q == ST_RUN) && (n_q == 3'd0) && (k_q == 3'd0))
		else $error("compute did not start");

	// products are only issued while running
	a_issue_running: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q != ST_IDLE))
		else $error("product issued while idle");

endmodule

// ----- tb/sv/svd_recovery_checker.sv -----
// ----------------------------------------------------------------------------
// svd_recovery_checker
// Watches the item, result and configuration channels of the left singular
// vector recovery block, keeps its own copy of A, V, S and the registers,
// predicts every U element of a compute and compares each result transfer.
// ----------------------------------------------------------------------------
module svd_recovery_checker
	import svd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_stall,
	input  item_t       item,
	input  logic        result_valid,
	input  logic        result_stall,
	input  result_t     result,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [15:0] a_mem [64];
	logic [15:0] v_mem [64];
	logic [15:0] sigma_mem [8];
	logic [3:0]  rows_reg;
	logic [3:0]  cols_reg;
	logic [15:0] floor_reg;
	result_t     u_expected [$];

	assign pending_count = u_expected.size();

	// predict all U elements for the current stores and registers
	task automatic predict_u();
		int nr, nc;
		longint s, sum, q, fl;
		result_t r;
		nr = (rows_reg == 0) ? 1 : (rows_reg > 8) ? 8 : rows_reg;
		nc = (cols_reg == 0) ? 1 : (cols_reg > 8) ? 8 : cols_reg;
		fl = (floor_reg == 0) ? 1 : floor_reg;
		for (int k = 0; k < nc; k++) begin
			s = longint'($signed(sigma_mem[k]));
			for (int m = 0; m < nr; m++) begin
				q = 0;
				if (s >= fl) begin
					sum = 0;
					for (int n = 0; n < nc; n++)
						sum += longint'($signed(a_mem[m*8+n])) * longint'($signed(v_mem[n*8+k]));
					q = (sum * 256) / s;
					if (q > 64'sd2147483647) q = 64'sd2147483647;
					if (q < -64'sd2147483648) q = -64'sd2147483648;
				end
				r.out_row = m[2:0];
				r.out_col = k[2:0];
				r.result_value = q[31:0];
				r.last = (k == nc - 1) && (m == nr - 1);
				u_expected.push_back(r);
			end
		end
	endtask

	// track config, loads and results on every rising edge
	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			rows_reg = 4'd8;
			cols_reg = 4'd8;
			floor_reg = 16'd1;
			fail_count = 0;
			u_expected.delete();
			for (int i = 0; i < 64; i++) begin
				a_mem[i] = '0;
				v_mem[i] = '0;
			end
			for (int i = 0; i < 8; i++) sigma_mem[i] = '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ROWS_IN_USE: rows_reg = cfg_data[3:0];
					REG_COLS_IN_USE: cols_reg = cfg_data[3:0];
					REG_SIGMA_FLOOR: floor_reg = cfg_data;
					default: ;
				endcase
			end
			if (item_valid && !item_stall) begin
				case (item.kind)
					KIND_LOAD_A:     a_mem[item.row*8+item.col] = item.value;
					KIND_LOAD_V:     v_mem[item.row*8+item.col] = item.value;
					KIND_LOAD_SIGMA: sigma_mem[item.col] = item.value;
					KIND_COMPUTE:    predict_u();
					default: ;
				endcase
			end
			if (result_valid && !result_stall) begin
				if (u_expected.size() == 0) begin
					$display("%0t: unexpected result %p", $time, result);
					fail_count++;
				end else begin
					e = u_expected.pop_front();
					if (result !== e) begin
						$display("%0t: mismatch expected row %0d col %0d value %0d last %0b",
							$time, e.out_row, e.out_col, e.result_value, e.last);
						$display("%0t:          actual   row %0d col %0d value %0d last %0b",
							$time, result.out_row, result.out_col, result.result_value,
							result.last);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

// ----- tb/sv/tb_svd_left_vector_recovery.sv -----
// ----------------------------------------------------------------------------
// tb_svd_left_vector_recovery
// Stimulus for the left singular vector recovery block: fills A, V and S,
// issues computes under several register settings with random idling on
// both channels; the checker module predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_svd_left_vector_recovery
	import svd_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int DRAIN_CYCLES = 120;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	item_t       item;
	logic        result_valid;
	logic        result_stall;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	int          fail_count;
	int          pending_count;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          cycle_count;
	int          item_total;
	int          nrows;
	int          ncols;

	svd_left_vector_recovery i_dut (.*);

	svd_recovery_checker i_checker (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// cycle limit
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// receiver stall
	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// one item transfer with random sender gaps; valid stays up after the
	// transfer until the next item or a quiet wait takes it down
	task automatic send_item(input logic [1:0] kind, input logic [2:0] row,
			input logic [2:0] col, input logic [15:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item.kind <= kind;
		item.row <= row;
		item.col <= col;
		item.value <= value;
		do @(posedge clk); while (item_stall);
		@(negedge clk);
		item_total++;
	endtask

	// one register write; the caller drops cfg_valid after the last one
	task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// wait for all expected results, then let the pipeline settle
	task automatic wait_quiet();
		item_valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_sizes(input int r, input int c, input logic [15:0] fl);
		wait_quiet();
		write_reg(REG_ROWS_IN_USE, 16'(r));
		write_reg(REG_COLS_IN_USE, 16'(c));
		write_reg(REG_SIGMA_FLOOR, fl);
		cfg_valid <= 1'b0;
		nrows = (r == 0) ? 1 : (r > 8) ? 8 : r;
		ncols = (c == 0) ? 1 : (c > 8) ? 8 : c;
	endtask

	// fill every store entry so no compute reads an unwritten one
	task automatic fill_all(input int mode);
		logic [15:0] v;
		for (int r = 0; r < 8; r++)
			for (int c = 0; c < 8; c++) begin
				v = (mode == 0) ? 16'h7fff : (mode == 1) ? 16'h8000 : 16'($urandom);
				send_item(KIND_LOAD_A, r[2:0], c[2:0], v);
				send_item(KIND_LOAD_V, r[2:0], c[2:0], v);
			end
		for (int c = 0; c < 8; c++)
			send_item(KIND_LOAD_SIGMA, 3'd0, c[2:0], (mode == 2) ? 16'($urandom) : 16'h0001);
	endtask

	// random phase: loads within the active sizes and occasional computes, then a final compute
	task automatic random_block(input int n_items);
		int kind;
		logic [15:0] v;
		for (int i = 0; i < n_items; i++) begin
			kind = $urandom_range(9);
			case ($urandom_range(3))
				0: v = 16'($urandom);
				1: v = 16'($signed(16'($urandom_range(1023))) - 16'sd512);
				2: v = $urandom_range(1) ? 16'h7fff : 16'h8000;
				default: v = 16'($urandom_range(2047));
			endcase
			if (kind < 4)
				send_item(KIND_LOAD_A, 3'($urandom_range(nrows-1)), 3'($urandom_range(ncols-1)), v);
			else if (kind < 7)
				send_item(KIND_LOAD_V, 3'($urandom_range(ncols-1)), 3'($urandom_range(ncols-1)), v);
			else if (kind < 9)
				send_item(KIND_LOAD_SIGMA, 3'($urandom), 3'($urandom_range(ncols-1)), v);
			else
				send_item(KIND_COMPUTE, 3'($urandom), 3'($urandom), 16'($urandom));
		end
		send_item(KIND_COMPUTE, 3'd0, 3'd0, 16'd0);
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_ROWS_IN_USE;
		cfg_data = '0;
		send_idle_pct = 19;
		recv_idle_pct = 57;
		item_total = 0;
		nrows = 8;
		ncols = 8;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: saturating positive extremes at full size
		fill_all(0);
		send_item(KIND_COMPUTE, 3'd7, 3'd7, 16'hffff);
		// a negative column 0 saturates at the low end
		for (int r = 0; r < 8; r++)
			send_item(KIND_LOAD_V, r[2:0], 3'd0, 16'h8000);
		send_item(KIND_COMPUTE, 3'd0, 3'd0, 16'd0);
		// negative sigma, zero floor, out of range sizes
		send_item(KIND_LOAD_SIGMA, 3'd5, 3'd0, 16'hff00);
		send_item(KIND_LOAD_SIGMA, 3'd0, 3'd1, 16'h0100);
		set_sizes(0, 15, 16'd0);
		send_item(KIND_COMPUTE, 3'd0, 3'd0, 16'd0);
		set_sizes(15, 0, 16'hffff);
		send_item(KIND_COMPUTE, 3'd0, 3'd0, 16'd0);
		fill_all(2);
		set_sizes(8, 8, 16'h0100);
		send_item(KIND_COMPUTE, 3'd0, 3'd0, 16'd0);

		// random phases with changing sizes and idling
		while (item_total < 440) begin
			if (item_total > 390) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (item_total > 330) begin
				send_idle_pct = 57;
				recv_idle_pct = 19;
			end
			set_sizes($urandom_range(1, 8), $urandom_range(1, 8),
				$urandom_range(2) == 0 ? 16'($urandom) : 16'($urandom_range(1, 300)));
			random_block($urandom_range(10, 40));
		end

		wait_quiet();
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- files.f -----
sv/svd_pkg.sv
sv/svd_ram.sv
sv/svd_div_cell.sv
sv/svd_left_vector_recovery.sv
tb/sv/svd_recovery_checker.sv
tb/sv/tb_svd_left_vector_recovery.sv
